// ===== hdl/dhr_pkg.sv =====
// Shared constants, mode codes and ramp unit interface types for the deadband block.
package dhr_pkg;

   localparam int MAX_SETTLE = 4;
   localparam int TOLERANCE  = 1;
   localparam int DATA_WIDTH = 32;
   localparam int SAT_WIDTH  = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

   localparam int EXT_WIDTH  = 35;   // compare/offset width for sample and thresholds
   localparam int UA_WIDTH   = 32;   // |distance past edge|
   localparam int UB_WIDTH   = 33;   // |edge-to-level distance plus width|
   localparam int W_WIDTH    = 31;   // ramp width
   localparam int PROD_WIDTH = UA_WIDTH + UB_WIDTH;
   localparam int Q_WIDTH    = 41;   // quotient bits up to and above the cap
   localparam int Y_WIDTH    = 42;   // level plus capped ramp term

   localparam logic signed [Y_WIDTH-1:0] SAT_HI =
      Y_WIDTH'((longint'(1) << (SAT_WIDTH - 1)) - 1);
   localparam logic signed [Y_WIDTH-1:0] SAT_LO = -SAT_HI - Y_WIDTH'(1);

   localparam logic [2:0] MODE_NORMAL    = 3'd0;
   localparam logic [2:0] MODE_OUTSIDE   = 3'd1;
   localparam logic [2:0] MODE_SHIFTED   = 3'd2;
   localparam logic [2:0] MODE_RAMP_UP   = 3'd3;
   localparam logic [2:0] MODE_RAMP_DOWN = 3'd4;

   localparam logic [2:0] REG_BAND_LEVEL   = 3'd0;
   localparam logic [2:0] REG_BAND_HIGH    = 3'd1;
   localparam logic [2:0] REG_BAND_LOW     = 3'd2;
   localparam logic [2:0] REG_RAMP_UP_W    = 3'd3;
   localparam logic [2:0] REG_RAMP_DOWN_W  = 3'd4;
   localparam logic [2:0] REG_RETURN_HIGH  = 3'd5;
   localparam logic [2:0] REG_RETURN_LOW   = 3'd6;
   localparam logic [2:0] REG_SHIFTED_MODE = 3'd7;

   typedef struct packed {
      logic                start;
      logic [UA_WIDTH-1:0] ua;
      logic [UB_WIDTH-1:0] ub;
      logic [W_WIDTH-1:0]  width;
   } ramp_req_type;

   typedef struct packed {
      logic               done;
      logic [Q_WIDTH-1:0] mag;
   } ramp_rsp_type;

endpackage

// ===== hdl/dhr_ramp_unit.sv =====
// Ramp term unit: two-pass multiply, then restoring divide, magnitude capped at 2^40.
module dhr_ramp_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  dhr_pkg::ramp_req_type ramp_req,
   output dhr_pkg::ramp_rsp_type ramp_rsp
);
   import dhr_pkg::*;

   typedef enum logic [2:0] {R_IDLE, R_MUL, R_LOAD, R_DIV, R_FIN} rstate_type;

   localparam int CntW = $clog2(Q_WIDTH);
   localparam logic [Q_WIDTH-1:0] Cap = Q_WIDTH'(1) << (Q_WIDTH - 1);
   localparam int HiW = UB_WIDTH - 17;

   rstate_type              state_ff;
   logic                    phase_ff;
   logic [UA_WIDTH-1:0]     ua_ff;
   logic [UB_WIDTH-1:0]     ub_ff;
   logic [W_WIDTH-1:0]      w_ff;
   logic [PROD_WIDTH-1:0]   prod_ff;
   logic [W_WIDTH-1:0]      rem_ff;
   logic [Q_WIDTH-1:0]      qr_ff;
   logic [CntW-1:0]         cnt_ff;
   logic [Q_WIDTH-1:0]      mag_ff;
   logic                    done_ff;

   logic [16:0]             mop;
   logic [UA_WIDTH+16:0]    pp;
   logic [PROD_WIDTH-Q_WIDTH-1:0] top_bits;
   logic [W_WIDTH:0]        trial;
   logic                    ge;
   logic [W_WIDTH:0]        diff;

   assign mop      = phase_ff ? 17'({1'b0, ub_ff[UB_WIDTH-1:17]}) : ub_ff[16:0];
   assign pp       = ua_ff * mop;
   assign top_bits = prod_ff[PROD_WIDTH-1:Q_WIDTH];
   assign trial    = {rem_ff, qr_ff[Q_WIDTH-1]};
   assign ge       = trial >= {1'b0, w_ff};
   assign diff     = trial - {1'b0, w_ff};

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      case (state_ff)
         R_IDLE: begin
            if (ramp_req.start) begin
               ua_ff    <= ramp_req.ua;
               ub_ff    <= ramp_req.ub;
               w_ff     <= ramp_req.width;
               phase_ff <= 1'b0;
               state_ff <= R_MUL;
            end
         end
         R_MUL: begin
            if (!phase_ff) begin
               prod_ff  <= PROD_WIDTH'(pp);
               phase_ff <= 1'b1;
            end else begin
               prod_ff  <= prod_ff + (PROD_WIDTH'(pp) << 17);
               state_ff <= R_LOAD;
            end
         end
         R_LOAD: begin
            if (W_WIDTH'(top_bits) >= w_ff || HiW'(top_bits >> W_WIDTH) != '0) begin
               mag_ff   <= Cap;
               done_ff  <= 1'b1;
               state_ff <= R_IDLE;
            end else begin
               rem_ff   <= W_WIDTH'(top_bits);
               qr_ff    <= prod_ff[Q_WIDTH-1:0];
               cnt_ff   <= '0;
               state_ff <= R_DIV;
            end
         end
         R_DIV: begin
            rem_ff <= ge ? diff[W_WIDTH-1:0] : trial[W_WIDTH-1:0];
            qr_ff  <= {qr_ff[Q_WIDTH-2:0], ge};
            cnt_ff <= cnt_ff + CntW'(1);
            if (cnt_ff == CntW'(Q_WIDTH - 1)) begin
               state_ff <= R_FIN;
            end
         end
         R_FIN: begin
            mag_ff   <= qr_ff[Q_WIDTH-1] ? Cap : qr_ff;
            done_ff  <= 1'b1;
            state_ff <= R_IDLE;
         end
         default: begin
            state_ff <= R_IDLE;
         end
      endcase
      if (reset) begin
         state_ff <= R_IDLE;
         done_ff  <= 1'b0;
      end
   end

   assign ramp_rsp.done = done_ff;
   assign ramp_rsp.mag  = mag_ff;

`ifndef SYNTHESIS
   a_div_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == R_DIV) |-> (cnt_ff <= CntW'(Q_WIDTH - 1)))
      else $error("divide step count overrun");
   a_mag_cap: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (mag_ff <= Cap))
      else $error("ramp magnitude above cap");
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == R_DIV) |-> (rem_ff < w_ff))
      else $error("divide remainder not below divisor");
`endif

endmodule

// ===== hdl/deadband_hysteresis_ramp.sv =====
// Top level: deadband with hysteresis and ramps, CSR bank, mode sequencer, output register.
//
// One signed Q16.16 word enters on req_ (valid/ready); one result word leaves on
// rsp_ (valid/ready): output value, final mode, side flag and a mode-changed flag.
// Registers are written over the csr_ APB port at byte address 4*index; pready
// is tied high. Write them only while the block is idle.
// Each word first runs up to MAX_SETTLE transition passes, one pass per cycle,
// then the output is formed. A ramp output adds the ramp unit: a two-pass
// 32x17 multiply, an overflow check and a 41-step restoring divide, one
// quotient bit per cycle. req_ready is high only while no word is in progress.
// The result sits in an output register; the next word may be accepted and
// processed while it waits, and a finished word holds in the sequencer until
// the output register frees up.
// Reset (synchronous, active high) clears the registers, the mode to normal,
// the side flag, the return-level write marks and the response valid flag.
module deadband_hysteresis_ramp (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_sample,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_out_value,
   output logic [2:0]  rsp_band_mode,
   output logic        rsp_left_high,
   output logic        rsp_mode_changed,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import dhr_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_SETTLE, S_EVAL, S_RAMP, S_FINISH} state_type;

   localparam int SetW = $clog2(MAX_SETTLE + 1);
   localparam logic signed [EXT_WIDTH-1:0] TolExt = EXT_WIDTH'(TOLERANCE);

   state_type                state_ff;
   logic signed [31:0]       lvl_ff, bh_ff, bl_ff, rh_ff, rl_ff;
   logic [W_WIDTH-1:0]       ru_ff, rd_ff;
   logic                     sh_ff, rhw_ff, rlw_ff;
   logic [2:0]               mode_ff;
   logic                     side_ff;
   logic                     changed_ff;
   logic [SetW-1:0]          cnt_ff;
   logic signed [31:0]       x_ff;
   logic signed [Y_WIDTH-1:0] y_ff;
   logic                     neg_ff;
   logic                     rsp_valid_ff;
   logic [31:0]              out_value_ff;
   logic [2:0]               out_mode_ff;
   logic                     out_side_ff;
   logic                     out_changed_ff;

   logic                     wr;
   logic [2:0]               idx;
   logic signed [EXT_WIDTH-1:0] xe, bh_e, bl_e, lv_e, rh_e, rl_e, ru_e, rd_e, rw_e, w_e;
   logic signed [EXT_WIDTH-1:0] a_e, b_e, a_abs, b_abs, shift_e;
   logic [2:0]               mode_in;
   logic                     side_in;
   logic                     active;
   logic                     is_ramp;
   logic                     load_out;
   logic signed [Y_WIDTH-1:0] y_sat;
   ramp_req_type             ramp_req;
   ramp_rsp_type             ramp_rsp;

   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign idx        = csr_paddr[4:2];
   assign csr_pready = 1'b1;

   always_comb begin
      case (idx)
         REG_BAND_LEVEL:   csr_prdata = lvl_ff;
         REG_BAND_HIGH:    csr_prdata = bh_ff;
         REG_BAND_LOW:     csr_prdata = bl_ff;
         REG_RAMP_UP_W:    csr_prdata = {1'b0, ru_ff};
         REG_RAMP_DOWN_W:  csr_prdata = {1'b0, rd_ff};
         REG_RETURN_HIGH:  csr_prdata = rh_ff;
         REG_RETURN_LOW:   csr_prdata = rl_ff;
         REG_SHIFTED_MODE: csr_prdata = {31'b0, sh_ff};
         default:          csr_prdata = '0;
      endcase
   end

   assign xe   = EXT_WIDTH'(x_ff);
   assign bh_e = EXT_WIDTH'(bh_ff);
   assign bl_e = EXT_WIDTH'(bl_ff);
   assign lv_e = EXT_WIDTH'(lvl_ff);
   assign ru_e = EXT_WIDTH'(ru_ff);
   assign rd_e = EXT_WIDTH'(rd_ff);
   assign rh_e = rhw_ff ? EXT_WIDTH'(rh_ff) : bh_e - EXT_WIDTH'(1);
   assign rl_e = rlw_ff ? EXT_WIDTH'(rl_ff) : bl_e + EXT_WIDTH'(1);
   assign rw_e = (mode_ff == MODE_RAMP_UP) ? ru_e : rd_e;
   assign active = bl_ff < bh_ff;

   // one settle pass
   always_comb begin
      mode_in = mode_ff;
      side_in = side_ff;
      case (mode_ff)
         MODE_OUTSIDE: begin
            if (side_ff) begin
               if (xe < rh_e) begin
                  mode_in = (rd_e > 0 && xe >= rh_e - rd_e) ? MODE_RAMP_DOWN : MODE_NORMAL;
               end
            end else if (xe > rl_e) begin
               mode_in = (rd_e > 0 && xe <= rl_e + rd_e) ? MODE_RAMP_DOWN : MODE_NORMAL;
            end
         end
         MODE_SHIFTED: begin
            if (xe < bh_e - TolExt && xe > bl_e + TolExt) begin
               mode_in = MODE_NORMAL;
            end
         end
         MODE_RAMP_UP, MODE_RAMP_DOWN: begin
            if (side_ff) begin
               if (xe > bh_e + rw_e + TolExt) begin
                  mode_in = MODE_OUTSIDE;
               end else if (xe < bh_e - TolExt) begin
                  mode_in = MODE_NORMAL;
               end
            end else begin
               if (xe < bl_e - rw_e - TolExt) begin
                  mode_in = MODE_OUTSIDE;
               end else if (xe > bl_e + TolExt) begin
                  mode_in = MODE_NORMAL;
               end
            end
         end
         default: begin
            mode_in = MODE_NORMAL;
            if (xe > bh_e + TolExt || xe < bl_e - TolExt) begin
               side_in = xe >= bh_e;
               if (sh_ff) begin
                  mode_in = MODE_SHIFTED;
               end else if (ru_ff != '0) begin
                  mode_in = MODE_RAMP_UP;
               end else begin
                  mode_in = MODE_OUTSIDE;
               end
            end
         end
      endcase
   end

   // output terms
   assign is_ramp = (mode_ff == MODE_RAMP_UP) || (mode_ff == MODE_RAMP_DOWN);
   assign w_e     = rw_e;
   assign shift_e = (xe > lv_e) ? xe - (bh_e - lv_e) : xe + (lv_e - bl_e);
   assign a_e     = (xe > lv_e) ? xe - bh_e : bl_e - xe;
   assign b_e     = (xe > lv_e) ? bh_e - lv_e + w_e : lv_e - bl_e + w_e;
   assign a_abs   = a_e[EXT_WIDTH-1] ? -a_e : a_e;
   assign b_abs   = b_e[EXT_WIDTH-1] ? -b_e : b_e;

   assign ramp_req.start = (state_ff == S_EVAL) && is_ramp && (w_e != 0);
   assign ramp_req.ua    = a_abs[UA_WIDTH-1:0];
   assign ramp_req.ub    = b_abs[UB_WIDTH-1:0];
   assign ramp_req.width = w_e[W_WIDTH-1:0];

   dhr_ramp_unit u_ramp (
      .clock    (clock),
      .reset    (reset),
      .ramp_req (ramp_req),
      .ramp_rsp (ramp_rsp)
   );

   assign load_out = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);
   assign y_sat    = (y_ff > SAT_HI) ? SAT_HI : ((y_ff < SAT_LO) ? SAT_LO : y_ff);

   always_ff @(posedge clock) begin
      if (wr) begin
         case (idx)
            REG_BAND_LEVEL:   lvl_ff <= csr_pwdata;
            REG_BAND_HIGH:    bh_ff  <= csr_pwdata;
            REG_BAND_LOW:     bl_ff  <= csr_pwdata;
            REG_RAMP_UP_W:    ru_ff  <= csr_pwdata[W_WIDTH-1:0];
            REG_RAMP_DOWN_W:  rd_ff  <= csr_pwdata[W_WIDTH-1:0];
            REG_RETURN_HIGH: begin
               rh_ff  <= csr_pwdata;
               rhw_ff <= 1'b1;
            end
            REG_RETURN_LOW: begin
               rl_ff  <= csr_pwdata;
               rlw_ff <= 1'b1;
            end
            REG_SHIFTED_MODE: sh_ff  <= csr_pwdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               x_ff       <= req_sample;
               changed_ff <= 1'b0;
               cnt_ff     <= '0;
               state_ff   <= S_SETTLE;
            end
         end
         S_SETTLE: begin
            if (!active || mode_in == mode_ff) begin
               state_ff <= S_EVAL;
            end else begin
               mode_ff    <= mode_in;
               side_ff    <= side_in;
               changed_ff <= 1'b1;
               cnt_ff     <= cnt_ff + SetW'(1);
               if (cnt_ff == SetW'(MAX_SETTLE - 1)) begin
                  state_ff <= S_EVAL;
               end
            end
         end
         S_EVAL: begin
            neg_ff   <= (xe <= lv_e) ^ (a_e[EXT_WIDTH-1] ^ b_e[EXT_WIDTH-1]);
            state_ff <= S_FINISH;
            case (mode_ff)
               MODE_OUTSIDE: y_ff <= Y_WIDTH'(x_ff);
               MODE_SHIFTED: y_ff <= Y_WIDTH'(shift_e);
               MODE_RAMP_UP, MODE_RAMP_DOWN: begin
                  y_ff <= Y_WIDTH'(x_ff);
                  if (w_e != 0) begin
                     state_ff <= S_RAMP;
                  end
               end
               default: y_ff <= Y_WIDTH'(lvl_ff);
            endcase
         end
         S_RAMP: begin
            if (ramp_rsp.done) begin
               y_ff     <= neg_ff ? Y_WIDTH'(lvl_ff) - Y_WIDTH'(ramp_rsp.mag)
                                  : Y_WIDTH'(lvl_ff) + Y_WIDTH'(ramp_rsp.mag);
               state_ff <= S_FINISH;
            end
         end
         S_FINISH: begin
            if (load_out) begin
               state_ff <= S_IDLE;
            end
         end
         default: begin
            state_ff <= S_IDLE;
         end
      endcase

      if (load_out) begin
         out_value_ff   <= y_sat[31:0];
         out_mode_ff    <= mode_ff;
         out_side_ff    <= side_ff;
         out_changed_ff <= changed_ff;
         rsp_valid_ff   <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff   <= 1'b0;
      end

      if (reset) begin
         state_ff     <= S_IDLE;
         lvl_ff       <= '0;
         bh_ff        <= '0;
         bl_ff        <= '0;
         ru_ff        <= '0;
         rd_ff        <= '0;
         rh_ff        <= '0;
         rl_ff        <= '0;
         sh_ff        <= 1'b0;
         rhw_ff       <= 1'b0;
         rlw_ff       <= 1'b0;
         mode_ff      <= MODE_NORMAL;
         side_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_value    = out_value_ff;
   assign rsp_band_mode    = out_mode_ff;
   assign rsp_left_high    = out_side_ff;
   assign rsp_mode_changed = out_changed_ff;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("accepted a word while busy");
   a_ramp_width: assert property (@(posedge clock) disable iff (reset)
      ramp_req.start |-> (ramp_req.width != '0))
      else $error("ramp started with zero width");
   a_ramp_done_state: assert property (@(posedge clock) disable iff (reset)
      ramp_rsp.done |-> (state_ff == S_RAMP))
      else $error("ramp result outside ramp wait");
   a_settle_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SETTLE) |-> (cnt_ff < SetW'(MAX_SETTLE)))
      else $error("settle pass count overrun");
   a_mode_frozen: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SETTLE && !active) |=> $stable(mode_ff))
      else $error("mode moved with inactive band");
`endif

endmodule

// ===== dv/deadband_hysteresis_ramp_test.sv =====
// Self-checking testbench for the deadband hysteresis ramp block: directed table, random phases.
`timescale 1ns / 1ps

module deadband_hysteresis_ramp_test;
   import dhr_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 80;
   localparam int PHASES      = 10;

   typedef struct packed {
      logic [31:0] value;
      logic [2:0]  mode;
      logic        high;
      logic        changed;
   } band_result_type;

   typedef struct {
      bit              is_reg;
      logic [2:0]      idx;
      logic [31:0]     data;
      bit              typed;
      band_result_type want;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_sample = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_out_value;
   logic [2:0]  rsp_band_mode;
   logic        rsp_left_high;
   logic        rsp_mode_changed;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   deadband_hysteresis_ramp dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor copy of the registers and state
   longint     lvl = 0, bhi = 0, blo = 0, rhi = 0, rlo = 0, rup = 0, rdn = 0;
   bit         shf = 0, rh_set = 0, rl_set = 0, side = 0;
   logic [2:0] cur_mode = MODE_NORMAL;

   band_result_type pending_outputs[$];
   plan_row_type    plan[$];
   int              mismatch_count = 0;
   int              cycle_count = 0;
   bit              burst = 0;
   bit              hold_rsp = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("deadband_hysteresis_ramp_test: done, errors");
         $finish;
      end
   end

   function automatic longint ret_high();
      return rh_set ? rhi : bhi - 1;
   endfunction

   function automatic longint ret_low();
      return rl_set ? rlo : blo + 1;
   endfunction

   // trunc(a*b/w), magnitude capped at 2^40, 64-bit unsigned arithmetic
   function automatic longint ramp_mag(longint a, longint b, longint unsigned w);
      bit                neg;
      longint unsigned   ua, ub, q1, r1, mag, cap;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? longint'(-a) : a;
      ub = (b < 0) ? longint'(-b) : b;
      cap = 64'd1 << 40;
      q1 = ua / w;
      r1 = ua % w;
      if (q1 != 0 && ub > cap / q1) mag = cap;
      else mag = q1 * ub + (r1 * ub) / w;
      if (mag > cap) mag = cap;
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic logic [2:0] settle_next(longint x);
      longint rh, rl, rw;
      rh = ret_high();
      rl = ret_low();
      case (cur_mode)
         MODE_OUTSIDE: begin
            if (side) begin
               if (x < rh) return (rdn > 0 && x >= rh - rdn) ? MODE_RAMP_DOWN : MODE_NORMAL;
            end else if (x > rl) begin
               return (rdn > 0 && x <= rl + rdn) ? MODE_RAMP_DOWN : MODE_NORMAL;
            end
            return MODE_OUTSIDE;
         end
         MODE_SHIFTED: begin
            if (x < bhi - TOLERANCE && x > blo + TOLERANCE) return MODE_NORMAL;
            return MODE_SHIFTED;
         end
         MODE_RAMP_UP, MODE_RAMP_DOWN: begin
            rw = (cur_mode == MODE_RAMP_UP) ? rup : rdn;
            if (side) begin
               if (x > bhi + rw + TOLERANCE) return MODE_OUTSIDE;
               if (x < bhi - TOLERANCE) return MODE_NORMAL;
            end else begin
               if (x < blo - rw - TOLERANCE) return MODE_OUTSIDE;
               if (x > blo + TOLERANCE) return MODE_NORMAL;
            end
            return cur_mode;
         end
         default: begin
            if (x > bhi + TOLERANCE || x < blo - TOLERANCE) begin
               side = (x >= bhi);
               if (shf) return MODE_SHIFTED;
               if (rup > 0) return MODE_RAMP_UP;
               return MODE_OUTSIDE;
            end
            return MODE_NORMAL;
         end
      endcase
   endfunction

   function automatic longint mode_output(longint x);
      longint w;
      case (cur_mode)
         MODE_OUTSIDE: return x;
         MODE_SHIFTED: return (x > lvl) ? x - (bhi - lvl) : x + (lvl - blo);
         MODE_RAMP_UP, MODE_RAMP_DOWN: begin
            w = (cur_mode == MODE_RAMP_UP) ? rup : rdn;
            if (w == 0) return x;
            if (x > lvl) return lvl + ramp_mag(x - bhi, bhi - lvl + w, w);
            return lvl - ramp_mag(blo - x, lvl - blo + w, w);
         end
         default: return lvl;
      endcase
   endfunction

   function automatic band_result_type deadband_step(logic [31:0] s);
      longint          x, y, hi, lo;
      logic [2:0]      nm;
      bit              chg;
      int              sat_w;
      band_result_type r;
      x = longint'($signed(s));
      chg = 0;
      if (blo < bhi) begin
         for (int pass = 0; pass < MAX_SETTLE; pass++) begin
            nm = settle_next(x);
            if (nm == cur_mode) break;
            cur_mode = nm;
            chg = 1;
         end
      end
      y = mode_output(x);
      sat_w = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
      hi = (longint'(1) <<< (sat_w - 1)) - 1;
      lo = -hi - 1;
      if (y > hi) y = hi;
      if (y < lo) y = lo;
      r.value = y[31:0];
      r.mode = cur_mode;
      r.high = side;
      r.changed = chg;
      return r;
   endfunction

   function automatic void apply_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
         REG_BAND_LEVEL:   lvl = longint'($signed(v));
         REG_BAND_HIGH:    bhi = longint'($signed(v));
         REG_BAND_LOW:     blo = longint'($signed(v));
         REG_RAMP_UP_W:    rup = longint'(v[30:0]);
         REG_RAMP_DOWN_W:  rdn = longint'(v[30:0]);
         REG_RETURN_HIGH: begin
            rhi = longint'($signed(v));
            rh_set = 1;
         end
         REG_RETURN_LOW: begin
            rlo = longint'($signed(v));
            rl_set = 1;
         end
         REG_SHIFTED_MODE: shf = v[0];
         default: ;
      endcase
   endfunction

   function automatic int draw_gap();
      return burst ? 0 : $urandom_range(0, 15);
   endfunction

   function automatic longint rnd_scaled(int sh);
      longint v;
      v = longint'($signed($urandom));
      return v >>> sh;
   endfunction

   function automatic logic [31:0] clip32(longint v);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      else if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   // points near every threshold the mode logic compares against, or a fully random word
   function automatic logic [31:0] pick_sample();
      longint p, off;
      case ($urandom_range(0, 10))
         0: p = bhi;
         1: p = blo;
         2: p = ret_high();
         3: p = ret_low();
         4: p = lvl;
         5: p = bhi + rup;
         6: p = blo - rup;
         7: p = bhi + rdn;
         8: p = blo - rdn;
         9: p = ret_high() - rdn;
         default: p = ret_low() + rdn;
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2, 3: off = longint'($urandom_range(0, 8)) - 4;
         4, 5, 6: off = rnd_scaled(15);
         7, 8: off = rnd_scaled(4);
         default: return $urandom;
      endcase
      return clip32(p + off);
   endfunction

   function automatic void plan_reg(logic [2:0] idx, logic [31:0] v);
      plan_row_type r;
      r.is_reg = 1;
      r.idx = idx;
      r.data = v;
      r.typed = 0;
      r.want = '0;
      plan.push_back(r);
   endfunction

   function automatic void plan_word(logic [31:0] s, bit typed, band_result_type want);
      plan_row_type r;
      r.is_reg = 0;
      r.idx = '0;
      r.data = s;
      r.typed = typed;
      r.want = want;
      plan.push_back(r);
   endfunction

   task automatic send_word(logic [31:0] s, bit typed, band_result_type want);
      int              gap;
      band_result_type r;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (!req_ready);
      r = deadband_step(s);
      pending_outputs.push_back(typed ? want : r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_outputs.size() != 0);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] v);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      apply_reg(idx, v);
      @(posedge clock);
   endtask

   task automatic load_settings(int ph);
      int          sh;
      longint      a, b, t;
      logic [31:0] lvl_w, hi_w, lo_w, ru_w, rd_w, rh_w, rl_w, sm_w;
      case ($urandom_range(0, 3))
         0: sh = 0;
         1: sh = 12;
         2: sh = 24;
         default: sh = 28;
      endcase
      lvl_w = 32'(rnd_scaled(sh));
      a = rnd_scaled(sh);
      b = rnd_scaled(sh);
      if ($urandom_range(0, 7) != 0 && a > b) begin
         t = a;
         a = b;
         b = t;
      end
      lo_w = 32'(a);
      hi_w = 32'(b);
      ru_w = $urandom >> sh;
      rd_w = $urandom >> sh;
      ru_w[31] = 1'($urandom_range(0, 1));
      rd_w[31] = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) ru_w[30:0] = '0;
      if ($urandom_range(0, 3) == 0) rd_w[30:0] = '0;
      rh_w = clip32(b + rnd_scaled(sh + 2));
      rl_w = clip32(a + rnd_scaled(sh + 2));
      sm_w = $urandom;
      if (ph == 0) begin
         lvl_w = 32'h7FFF_FFFF; hi_w = 32'h7FFF_FFFF; lo_w = 32'h8000_0000;
         ru_w = 32'hFFFF_FFFF; rd_w = 32'hFFFF_FFFF;
         rh_w = 32'h7FFF_FFFF; rl_w = 32'h8000_0000; sm_w = 32'h0;
      end else if (ph == 1) begin
         lvl_w = 32'h8000_0000; hi_w = 32'h0000_0001; lo_w = 32'h0000_0000;
         ru_w = 32'h1; rd_w = 32'h1;
         rh_w = 32'h8000_0000; rl_w = 32'h7FFF_FFFF; sm_w = 32'h1;
      end
      write_reg(REG_BAND_LEVEL, lvl_w);
      write_reg(REG_BAND_HIGH, hi_w);
      write_reg(REG_BAND_LOW, lo_w);
      write_reg(REG_RAMP_UP_W, ru_w);
      write_reg(REG_RAMP_DOWN_W, rd_w);
      write_reg(REG_RETURN_HIGH, rh_w);
      write_reg(REG_RETURN_LOW, rl_w);
      write_reg(REG_SHIFTED_MODE, sm_w);
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t %s: expected %h, got %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   initial begin
      int              stall;
      band_result_type want;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_rsp) begin
            stall = HOLD_CYCLES;
            hold_rsp = 0;
         end else begin
            stall = draw_gap();
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (pending_outputs.size() == 0) begin
            $display("%0t word with nothing expected: %h mode %0d", $time, rsp_out_value,
                     rsp_band_mode);
            mismatch_count++;
         end else begin
            want = pending_outputs.pop_front();
            check_field("out_value", want.value, rsp_out_value);
            check_field("band_mode", 32'(want.mode), 32'(rsp_band_mode));
            check_field("left_high", 32'(want.high), 32'(rsp_left_high));
            check_field("mode_changed", 32'(want.changed), 32'(rsp_mode_changed));
         end
      end
   end

   initial begin
      int     n, sent, steps, pos;
      longint lo_pt, hi_pt, t;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // inactive band after reset: level output, mode never moves
      plan_word(32'h0000_0000, 1, '{32'h0, MODE_NORMAL, 1'b0, 1'b0});
      plan_word(32'h7FFF_FFFF, 1, '{32'h0, MODE_NORMAL, 1'b0, 1'b0});
      plan_word(32'h8000_0000, 1, '{32'h0, MODE_NORMAL, 1'b0, 1'b0});
      // band +/-2.0, default return levels
      plan_reg(REG_BAND_HIGH, 32'h0002_0000);
      plan_reg(REG_BAND_LOW, 32'hFFFE_0000);
      plan_word(32'h0000_0000, 1, '{32'h0, MODE_NORMAL, 1'b0, 1'b0});
      plan_word(32'h0003_0000, 1, '{32'h0003_0000, MODE_OUTSIDE, 1'b1, 1'b1});
      plan_word(32'h0001_FFFF, 0, '0);
      plan_word(32'h0001_FFFE, 0, '0);
      plan_word(32'h8000_0000, 0, '0);
      plan_word(32'h7FFF_FFFF, 0, '0);
      // return levels beyond the edges: mode toggles until the settle limit
      plan_reg(REG_RETURN_HIGH, 32'h0004_0000);
      plan_reg(REG_RETURN_LOW, 32'hFFFC_0000);
      plan_word(32'h0003_0000, 0, '0);
      plan_word(32'h0000_0000, 0, '0);
      // shifted output, saturating high
      plan_reg(REG_SHIFTED_MODE, 32'h0000_0001);
      plan_reg(REG_BAND_LEVEL, 32'h7000_0000);
      plan_word(32'h7FFF_FFFF, 0, '0);
      plan_word(32'h8000_0000, 0, '0);
      plan_word(32'h0000_0000, 0, '0);
      // ramps on both sides
      plan_reg(REG_SHIFTED_MODE, 32'hFFFF_FFFE);
      plan_reg(REG_BAND_LEVEL, 32'h0000_0000);
      plan_reg(REG_RAMP_UP_W, 32'h0008_0000);
      plan_reg(REG_RAMP_DOWN_W, 32'h0004_0000);
      plan_reg(REG_RETURN_HIGH, 32'h0003_0000);
      plan_reg(REG_RETURN_LOW, 32'hFFFD_0000);
      plan_word(32'h0003_0000, 0, '0);
      plan_word(32'h000B_0000, 0, '0);
      plan_word(32'h0002_8000, 0, '0);
      plan_word(32'h0000_0000, 0, '0);
      plan_word(32'hFFFD_0000, 0, '0);
      // ramp width cleared mid-ramp: pass-through
      plan_reg(REG_RAMP_UP_W, 32'h8000_0000);
      plan_word(32'hFFFE_0000, 0, '0);
      plan_word(32'h0000_0000, 0, '0);
      // ramp magnitude hits the cap, then saturates low
      plan_reg(REG_BAND_LEVEL, 32'h8000_0000);
      plan_reg(REG_BAND_HIGH, 32'h7FFF_FFFF);
      plan_reg(REG_BAND_LOW, 32'h7FFF_0000);
      plan_reg(REG_RAMP_UP_W, 32'h0000_0001);
      plan_word(32'h0000_0000, 0, '0);
      plan_word(32'h7FFE_FFFE, 0, '0);

      foreach (plan[i]) begin
         if (plan[i].is_reg) begin
            drain();
            write_reg(plan[i].idx, plan[i].data);
         end else begin
            send_word(plan[i].data, plan[i].typed, plan[i].want);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         load_settings(ph);
         burst = ($urandom_range(0, 3) == 0) || ph == 4;
         if (ph == 4) hold_rsp = 1;
         n = $urandom_range(58, 72);
         sent = 0;
         while (sent < n) begin
            if ($urandom_range(0, 3) == 0) begin
               // sweep up through the band and back down
               t = (rup > rdn) ? rup : rdn;
               lo_pt = blo - t - 8;
               hi_pt = bhi + t + 8;
               if (lo_pt > hi_pt) begin
                  t = lo_pt;
                  lo_pt = hi_pt;
                  hi_pt = t;
               end
               steps = $urandom_range(4, 12);
               for (int j = 0; j <= 2 * steps; j++) begin
                  pos = (j <= steps) ? j : 2 * steps - j;
                  send_word(clip32(lo_pt + (hi_pt - lo_pt) * pos / steps), 0, '0);
               end
               sent += 2 * steps + 1;
            end else begin
               send_word(pick_sample(), 0, '0);
               sent++;
            end
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("deadband_hysteresis_ramp_test: done, clean");
      end else begin
         $display("deadband_hysteresis_ramp_test: done, errors");
      end
      $finish;
   end

endmodule
